// ----- sv/lsr1d_pkg.sv -----
// ----------------------------------------------------------------------------
// Level-set reinitialization package
// Shared constants, sequencer states and saturation helper.
// ----------------------------------------------------------------------------
package lsr1d_pkg;

    localparam int MAX_CELLS = 32;
    localparam int IDX_W     = $clog2(MAX_CELLS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int SAMPLE_W  = 32;
    localparam int SPACING_W = 31;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CELL_COUNT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SPACING    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_SPACING = 2'd2;

    localparam logic [CNT_W-1:0]     RST_CELL_COUNT      = CNT_W'(32);
    localparam logic [SPACING_W-1:0] RST_GRID_SPACING    = 31'd20480;
    localparam logic [SPACING_W-1:0] RST_INVERSE_SPACING = 31'd209715;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH_P,
        S_TAKE_P,
        S_FETCH_R,
        S_TAKE_R,
        S_CELL,
        S_R1,
        S_R2,
        S_R3,
        S_R4,
        S_R5,
        S_IF_MUL,
        S_IF_INIT,
        S_IF_DIV,
        S_IF_OUT
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] res;
        if (v > 40'sh007FFFFFFF) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -40'sh0080000000) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

// ----- sv/lsr1d_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lsr1d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- sv/levelset_redistance_1d_step_top.sv -----
// ----------------------------------------------------------------------------
// Level-set reinitialization sweep, 1D grid
// Samples are taken while idle; the transfer that completes a sweep sets busy,
// and the results follow one per cell. Regular cells take a shorter path than
// interface cells, which use a 64-step divider; a zero sample, a zero gradient
// term or a zero divisor shortens the path further.
// Results cannot be stalled. Synchronous active-low reset clears the load count
// and restores the configuration registers to their reset values.
// ----------------------------------------------------------------------------
module levelset_redistance_1d_step_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [lsr1d_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                 i_cfg_we,
    input  logic [lsr1d_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lsr1d_pkg::SPACING_W-1:0]      i_cfg_data,
    output logic                                 o_valid,
    output logic signed [lsr1d_pkg::SAMPLE_W-1:0] o_new_sample,
    output logic                                 o_last
);
    import lsr1d_pkg::*;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_load_cnt, n_load_cnt;
    logic [CNT_W-1:0] r_cell_cnt;
    logic [SPACING_W-1:0] r_h, r_inv;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic signed [31:0] r_l, n_l, r_p, n_p, r_r, n_r;
    logic [63:0] r_prod, n_prod;
    logic signed [48:0] r_dx0, n_dx0;
    logic [47:0] r_gm, n_gm;
    logic r_gpos, n_gpos, r_gzero, n_gzero;
    logic [63:0] r_t, n_t;
    logic [63:0] r_num, n_num;
    logic [33:0] r_rem, n_rem;
    logic [32:0] r_den, n_den;
    logic [5:0] r_bit, n_bit;
    logic r_valid, n_valid, r_last, n_last;
    logic signed [31:0] r_out, n_out;
    logic r_if_fin;

    logic [CNT_W-1:0] w_n, w_next_i;
    logic [IDX_W-1:0] w_raddr;
    logic [31:0] w_rdata;
    logic w_we;
    logic w_has_r, w_inner, w_edge_l, w_edge_r, w_is_last;
    logic signed [32:0] w_dl, w_dr, w_dlr;
    logic [32:0] w_ma;
    logic [30:0] w_mb;
    logic [63:0] w_mul;
    logic signed [48:0] w_dx1, w_ga, w_gb, w_gx, w_grad;
    logic [33:0] w_rem_sh;
    logic [33:0] w_tsum, w_tc;
    logic [32:0] w_qc;
    logic signed [33:0] w_f;
    logic signed [34:0] w_x, w_half;
    logic signed [39:0] w_vreg, w_vif;

    assign w_n = (r_cell_cnt == '0) ? CNT_W'(1) :
                 (r_cell_cnt > CNT_W'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : r_cell_cnt;
    assign w_next_i  = {1'b0, r_idx} + CNT_W'(1);
    assign w_has_r   = w_next_i < w_n;
    assign w_is_last = w_next_i == w_n;
    assign w_inner   = (r_idx != '0) && w_has_r;
    assign w_edge_l  = (r_p <= 0 && r_l >= 0) || (r_p >= 0 && r_l <= 0);
    assign w_edge_r  = (r_p <= 0 && r_r >= 0) || (r_p >= 0 && r_r <= 0);
    assign w_dl  = 33'(r_p) - 33'(r_l);
    assign w_dr  = 33'(r_r) - 33'(r_p);
    assign w_dlr = 33'(r_r) - 33'(r_l);
    assign w_we  = (r_state == S_IDLE) && start;
    assign w_raddr = (r_state == S_FETCH_P) ? '0 : w_next_i[IDX_W-1:0];

    lsr1d_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_CELLS)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_load_cnt[IDX_W-1:0]),
        .i_wdata (i_sample),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_mul = {31'b0, w_ma} * {33'b0, w_mb};

    always_comb begin
        w_dx1 = w_dr[32] ? -$signed({1'b0, r_prod[63:16]}) : $signed({1'b0, r_prod[63:16]});
        if (r_p > 0) begin
            w_ga = (r_dx0 > 0) ? r_dx0 : '0;
            w_gb = (w_dx1 < 0) ? -w_dx1 : '0;
        end else begin
            w_ga = (r_dx0 < 0) ? -r_dx0 : '0;
            w_gb = (w_dx1 > 0) ? w_dx1 : '0;
        end
        w_gx   = (w_ga > w_gb) ? w_ga : w_gb;
        w_grad = w_gx - 49'sd65536;
        w_rem_sh = {r_rem[32:0], r_num[63]};
        w_tsum = 34'(r_t + {17'b0, r_prod[63:17]});
        w_tc   = (r_t + {17'b0, r_prod[63:17]} > 64'h2_0000_0000) ? 34'h2_0000_0000 : w_tsum;
        w_vreg = ((r_p > 0) == r_gpos) ? 40'(r_p) - $signed({6'b0, w_tc})
                                       : 40'(r_p) + $signed({6'b0, w_tc});
        w_qc = (r_num > 64'h8000_0000) ? 33'h1_0000_0000 >> 1 : r_num[32:0];
        if (r_p < 0) begin
            w_f = -$signed({1'b0, w_qc});
        end else if (w_qc == 33'h0_8000_0000) begin
            w_f = 34'sh0_7FFF_FFFF;
        end else begin
            w_f = $signed({1'b0, w_qc});
        end
        w_x    = 35'(r_p) - 35'(w_f);
        w_half = (w_x + ((w_x < 0) ? 35'sd1 : 35'sd0)) >>> 1;
        w_vif  = 40'(r_p) - 40'(w_half);
    end

    always_comb begin
        n_state = r_state;
        n_load_cnt = r_load_cnt;
        n_idx = r_idx;
        n_l = r_l;
        n_p = r_p;
        n_r = r_r;
        n_prod = r_prod;
        n_dx0 = r_dx0;
        n_gm = r_gm;
        n_gpos = r_gpos;
        n_gzero = r_gzero;
        n_t = r_t;
        n_num = r_num;
        n_rem = r_rem;
        n_den = r_den;
        n_bit = r_bit;
        n_valid = 1'b0;
        n_last = 1'b0;
        n_out = r_out;
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (r_load_cnt + CNT_W'(1) >= w_n) begin
                        n_load_cnt = '0;
                        n_idx = '0;
                        n_state = S_FETCH_P;
                    end else begin
                        n_load_cnt = r_load_cnt + CNT_W'(1);
                    end
                end
            end
            S_FETCH_P: n_state = S_TAKE_P;
            S_TAKE_P: begin
                n_p = w_rdata;
                n_state = S_FETCH_R;
            end
            S_FETCH_R: n_state = w_has_r ? S_TAKE_R : S_CELL;
            S_TAKE_R: begin
                n_r = w_rdata;
                n_state = S_CELL;
            end
            S_CELL: begin
                if (w_inner && (w_edge_l || w_edge_r)) begin
                    n_state = S_IF_MUL;
                end else if (r_p == 0) begin
                    n_out = '0;
                    n_state = S_IF_OUT;
                end else begin
                    w_ma = (r_idx != '0) ? (w_dl[32] ? 33'(-w_dl) : 33'(w_dl)) : '0;
                    w_mb = r_inv;
                    n_prod = w_mul;
                    n_state = S_R1;
                end
            end
            S_R1: begin
                n_dx0 = w_dl[32] ? -$signed({1'b0, r_prod[63:16]})
                                 : $signed({1'b0, r_prod[63:16]});
                w_ma = w_has_r ? (w_dr[32] ? 33'(-w_dr) : 33'(w_dr)) : '0;
                w_mb = r_inv;
                n_prod = w_mul;
                n_state = S_R2;
            end
            S_R2: begin
                n_gm = w_grad[48] ? 48'(-w_grad) : 48'(w_grad);
                n_gpos = w_grad > 0;
                n_gzero = w_grad == 0;
                n_state = S_R3;
            end
            S_R3: begin
                if (r_gzero) begin
                    n_out = r_p;
                    n_state = S_IF_OUT;
                end else begin
                    w_ma = {9'b0, r_gm[47:24]};
                    w_mb = r_h;
                    n_prod = w_mul;
                    n_state = S_R4;
                end
            end
            S_R4: begin
                n_t = r_prod << 7;
                w_ma = {9'b0, r_gm[23:0]};
                w_mb = r_h;
                n_prod = w_mul;
                n_state = S_R5;
            end
            S_R5: begin
                n_out = sat32(w_vreg);
                n_state = S_IF_OUT;
            end
            S_IF_MUL: begin
                w_ma = r_p[31] ? 33'(-33'(r_p)) : 33'(r_p);
                w_mb = r_h;
                n_prod = w_mul;
                n_state = S_IF_INIT;
            end
            S_IF_INIT: begin
                n_den = w_dlr[32] ? 33'(-w_dlr) : 33'(w_dlr);
                n_rem = '0;
                n_bit = '0;
                if (w_dlr == 0) begin
                    n_num = '0;
                    n_state = S_IF_DIV;
                    n_bit = 6'd63;
                    n_den = 33'd1;
                    n_rem = '0;
                end else begin
                    n_num = r_prod << 1;
                    n_state = S_IF_DIV;
                end
            end
            S_IF_DIV: begin
                if (w_rem_sh >= {1'b0, r_den}) begin
                    n_rem = w_rem_sh - {1'b0, r_den};
                    n_num = {r_num[62:0], 1'b1};
                end else begin
                    n_rem = w_rem_sh;
                    n_num = {r_num[62:0], 1'b0};
                end
                n_bit = r_bit + 6'd1;
                if (r_bit == 6'd63) begin
                    n_state = S_IF_OUT;
                end
            end
            S_IF_OUT: begin
                if (r_if_fin) begin
                    n_out = sat32(w_vif);
                end
                n_valid = 1'b1;
                n_last = w_is_last;
                if (w_is_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_l = r_p;
                    n_p = r_r;
                    n_idx = w_next_i[IDX_W-1:0];
                    n_state = S_FETCH_R;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_load_cnt <= '0;
            r_cell_cnt <= RST_CELL_COUNT;
            r_h <= RST_GRID_SPACING;
            r_inv <= RST_INVERSE_SPACING;
            r_valid <= 1'b0;
            r_if_fin <= 1'b0;
        end else begin
            r_state <= n_state;
            r_load_cnt <= n_load_cnt;
            r_valid <= (r_state == S_IF_OUT) ? n_valid : 1'b0;
            r_if_fin <= (r_state == S_IF_DIV && r_bit == 6'd63);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CELL_COUNT:      r_cell_cnt <= i_cfg_data[CNT_W-1:0];
                    CFG_GRID_SPACING:    r_h <= i_cfg_data;
                    CFG_INVERSE_SPACING: r_inv <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_l <= n_l;
        r_p <= n_p;
        r_r <= n_r;
        r_prod <= n_prod;
        r_dx0 <= n_dx0;
        r_gm <= n_gm;
        r_gpos <= n_gpos;
        r_gzero <= n_gzero;
        r_t <= n_t;
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
        r_bit <= n_bit;
        r_last <= n_last;
        r_out <= n_out;
    end

    assign busy = r_state != S_IDLE;
    assign o_valid = r_valid;
    assign o_new_sample = r_out;
    assign o_last = r_last;
endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// Level-set reinitialization sweep testbench
// Loads samples through the sample port, predicts each sweep's cell values
// with an independent fixed-point model and checks every strobed result in
// order. Configuration changes happen only while the block is idle.
// ----------------------------------------------------------------------------
module tb;
    import lsr1d_pkg::*;

    typedef struct {
        logic signed [31:0] value;
        logic               last;
        logic               known;
    } t_cell_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic signed [31:0]   i_sample;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [SPACING_W-1:0] i_cfg_data;
    logic                 o_valid;
    logic signed [31:0]   o_new_sample;
    logic                 o_last;

    levelset_redistance_1d_step_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_sample     (i_sample),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_new_sample (o_new_sample),
        .o_last       (o_last)
    );

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 3000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    logic [5:0]         cell_count_q;
    logic [30:0]        spacing_q;
    logic [30:0]        inv_spacing_q;
    logic signed [31:0] grid[MAX_CELLS];
    int unsigned        loaded;
    t_cell_result       sweep_q[$];
    int                 errors;
    int                 idle_cycles;
    int                 results_seen;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d (result %0d)",
                 what, got, want, results_seen);
        errors++;
    endtask

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint slope(input longint d);
        longint unsigned m;
        m = d < 0 ? -d : d;
        m = (m * inv_spacing_q) >> 16;
        return d < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint interface_cell(input longint p, input longint l,
                                              input longint r);
        longint unsigned span, q, pm;
        longint f;
        f = 0;
        span = (r - l) < 0 ? l - r : r - l;
        pm = p < 0 ? -p : p;
        if (span != 0) begin
            q = (2 * longint'(spacing_q) * pm) / span;
            if (q > 64'h80000000) q = 64'h80000000;
            f = p < 0 ? -longint'(q) : clamp32(longint'(q));
        end
        return clamp32(p - (p - f) / 2);
    endfunction

    function automatic longint regular_cell(input longint p, input longint d0,
                                            input longint d1);
        longint ga, gb, g;
        longint unsigned gm, t;
        if (p == 0) return 0;
        if (p > 0) begin
            ga = d0 > 0 ? d0 : 0;
            gb = d1 < 0 ? -d1 : 0;
        end else begin
            ga = d0 < 0 ? -d0 : 0;
            gb = d1 > 0 ? d1 : 0;
        end
        g = (ga > gb ? ga : gb) - 65536;
        if (g == 0) return p;
        gm = g < 0 ? -g : g;
        t = ((longint'(spacing_q) * (gm >> 24)) << 7)
            + ((longint'(spacing_q) * (gm & 64'hFFFFFF)) >> 17);
        if (t > (64'd1 << 33)) t = 64'd1 << 33;
        if ((p > 0) == (g > 0)) return clamp32(p - longint'(t));
        return clamp32(p + longint'(t));
    endfunction

    task automatic predict_load(input logic signed [31:0] s);
        int n;
        longint p, l, r, v;
        t_cell_result e;
        n = cell_count_q == 0 ? 1 : (cell_count_q > MAX_CELLS ? MAX_CELLS : cell_count_q);
        if (loaded < MAX_CELLS) grid[loaded] = s;
        loaded++;
        if (loaded < n) return;
        loaded = 0;
        for (int i = 0; i < n; i++) begin
            p = grid[i];
            l = i > 0 ? grid[i-1] : 0;
            r = i + 1 < n ? grid[i+1] : 0;
            if (i > 0 && i + 1 < n && ((p <= 0 && l >= 0) || (p >= 0 && l <= 0)
                    || (p <= 0 && r >= 0) || (p >= 0 && r <= 0))) begin
                v = interface_cell(p, l, r);
            end else begin
                v = regular_cell(p, i > 0 ? slope(p - l) : 0,
                                 i + 1 < n ? slope(r - p) : 0);
            end
            e.value = v[31:0];
            e.last  = (i + 1 == n);
            e.known = 1'b0;
            sweep_q.push_back(e);
        end
    endtask

    always @(posedge i_clk) begin
        t_cell_result e;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (sweep_q.size() == 0) begin
                report("unexpected result", o_new_sample, 0);
            end else begin
                e = sweep_q.pop_front();
                if (o_new_sample !== e.value) begin
                    report(e.known ? "typed new_sample" : "new_sample",
                           o_new_sample, e.value);
                end
                if (o_last !== e.last) report("last", o_last, e.last);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic load_sample(input logic signed [31:0] s);
        int gap;
        gap = $urandom_range(0, 11);
        i_cfg_we <= 1'b0;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_sample <= s;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_load(s);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (sweep_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_CELL_COUNT:      cell_count_q  = data[5:0];
            CFG_GRID_SPACING:    spacing_q     = data;
            CFG_INVERSE_SPACING: inv_spacing_q = data;
            default: ;
        endcase
    endtask

    function automatic logic signed [31:0] rand_sample(input int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8;
            default: return $signed($urandom_range(0, 4096)) - 2048;
        endcase
    endfunction

    logic signed [31:0] directed_rows[] = '{
        32'sh7FFFFFFF, 32'sh80000000, 32'sh00000000, 32'sh00010000,
        -32'sh00010000, 32'sh00020000, 32'sh00020000, 32'sh00050000,
        32'sh00008000, -32'sh00008000, 32'sh00000000, 32'sh00000000,
        32'sh7FFFFFFF, 32'sh7FFFFFFF, -32'sh00000001, 32'sh00000001,
        32'sh80000000, 32'sh00030000, 32'sh00040000, 32'sh00050000
    };

    initial begin
        int n, sweeps;
        t_cell_result e;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_sample   = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        errors = 0;
        results_seen = 0;
        idle_cycles = 0;
        loaded = 0;
        cell_count_q  = 6'd32;
        spacing_q     = RST_GRID_SPACING;
        inv_spacing_q = RST_INVERSE_SPACING;
        foreach (grid[k]) grid[k] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A single-cell sweep of zero must stay zero after reset.
        write_reg(CFG_CELL_COUNT, 31'd1);
        load_sample(32'sd0);
        sweep_q[0].value = 32'sd0;
        sweep_q[0].known = 1'b1;
        wait_drained();
        write_reg(CFG_CELL_COUNT, 31'd5);
        foreach (directed_rows[k]) load_sample(directed_rows[k]);
        wait_drained();
        write_reg(CFG_CELL_COUNT, 31'd0);
        load_sample(32'sh7FFFFFFF);
        wait_drained();
        write_reg(CFG_CELL_COUNT, 31'd63);
        write_reg(CFG_GRID_SPACING, 31'h7FFFFFFF);
        write_reg(CFG_INVERSE_SPACING, 31'h7FFFFFFF);
        for (int k = 0; k < 32; k++) load_sample(k[0] ? 32'sh7FFFFFFF : 32'sh80000000);
        wait_drained();
        write_reg(CFG_GRID_SPACING, 31'd1);
        write_reg(CFG_INVERSE_SPACING, 31'd1);
        write_reg(CFG_UNMAPPED, 31'h1234);
        write_reg(CFG_CELL_COUNT, 31'd3);
        for (int k = 0; k < 3; k++) load_sample(rand_sample(0));
        wait_drained();

        sweeps = 0;
        while (results_seen < 430 || sweeps < 40) begin
            if ($urandom_range(0, 3) == 0) begin
                write_reg(CFG_GRID_SPACING, $urandom_range(0, 3) == 0
                          ? 31'($urandom()) : 31'($urandom_range(1, 131072)));
                write_reg(CFG_INVERSE_SPACING, $urandom_range(0, 3) == 0
                          ? 31'($urandom()) : 31'($urandom_range(1, 1 << 20)));
            end
            n = $urandom_range(0, 9) == 0 ? $urandom_range(17, 63) : $urandom_range(1, 12);
            write_reg(CFG_CELL_COUNT, 31'(n));
            if (n == 0) n = 1;
            if (n > MAX_CELLS) n = MAX_CELLS;
            begin
                int mode;
                mode = $urandom_range(0, 2);
                for (int k = 0; k < n; k++) load_sample(rand_sample(mode));
            end
            wait_drained();
            sweeps++;
        end

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/lsr1d_pkg.sv
sv/lsr1d_ram.sv
sv/levelset_redistance_1d_step_top.sv
verif/tb.sv
